@@ rtl/devanagari_to_iast_stream_top_defines.svh @@
// Assertion macros for the Devanagari to IAST stream block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DEVANAGARI_TO_IAST_STREAM_TOP_DEFINES_SVH
`define DEVANAGARI_TO_IAST_STREAM_TOP_DEFINES_SVH

// same-cycle implication
`define D2I_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define D2I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/d2i_pkg.sv @@
// Shared types, constants and lookup functions for the Devanagari to IAST block.
// No dependencies.
`timescale 1ns / 1ps

package d2i_pkg;

    localparam int HOLD_DEPTH_DEF = 4;
    // most bytes a single item can add: joiner + non-joiner + 3-byte vowel spelling
    localparam int CMD_BYTES      = 9;
    localparam int CMD_W          = CMD_BYTES * 8;

    localparam logic [20:0] CP_ZWJ     = 21'h00200d;
    localparam logic [7:0]  INHERENT_A = 8'h61;
    // UTF-8 of the joiner and non-joiner, first byte in the low bits
    localparam logic [23:0] ZWJ_UTF8   = 24'h8d80e2;
    localparam logic [23:0] ZWNJ_UTF8  = 24'h8c80e2;

    typedef enum logic [2:0] {
        KIND_CONS,
        KIND_VOWEL,
        KIND_VSIGN,
        KIND_CODA,
        KIND_NUM,
        KIND_SPEC
    } kind_t;

    typedef struct packed {
        logic        hit;
        kind_t       kind;
        logic [2:0]  len;
        logic [31:0] bytes;   // first byte in [7:0]
    } rom_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] bytes;   // first byte in [7:0]
    } utf8_t;

    // One classified item handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0] data;      // new bytes, first in [7:0]
        logic [3:0]       len;
        logic             drop_last; // joiner before a vowel sign
        logic             drop_if_a; // vowel sign eats an inherent a
        logic             flush;
    } cmd_t;

    // spelling given in reading order, most significant byte first
    function automatic rom_t mk(kind_t k, logic [2:0] n, logic [31:0] b);
        rom_t r;
        r.hit   = 1'b1;
        r.kind  = k;
        r.len   = n;
        r.bytes = {b[7:0], b[15:8], b[23:16], b[31:24]};
        return r;
    endfunction

    function automatic rom_t rom_lookup(logic [20:0] cp);
        rom_t r;
        r = '{hit: 1'b0, kind: KIND_SPEC, len: 3'd0, bytes: 32'h0};
        case (cp)
            21'h0950: r = mk(KIND_SPEC,  3'd3, 32'h61756d00);
            21'h0910: r = mk(KIND_VOWEL, 3'd2, 32'h61690000);
            21'h0914: r = mk(KIND_VOWEL, 3'd2, 32'h61750000);
            21'h0905: r = mk(KIND_VOWEL, 3'd1, 32'h61000000);
            21'h0906: r = mk(KIND_VOWEL, 3'd2, 32'hc4810000);
            21'h0907: r = mk(KIND_VOWEL, 3'd1, 32'h69000000);
            21'h0908: r = mk(KIND_VOWEL, 3'd2, 32'hc4ab0000);
            21'h0909: r = mk(KIND_VOWEL, 3'd1, 32'h75000000);
            21'h090a: r = mk(KIND_VOWEL, 3'd2, 32'hc5ab0000);
            21'h090b: r = mk(KIND_VOWEL, 3'd3, 32'he1b99b00);
            21'h0960: r = mk(KIND_VOWEL, 3'd3, 32'he1b99d00);
            21'h090c: r = mk(KIND_VOWEL, 3'd3, 32'he1b8b700);
            21'h0961: r = mk(KIND_VOWEL, 3'd3, 32'he1b8b900);
            21'h090f: r = mk(KIND_VOWEL, 3'd1, 32'h65000000);
            21'h0913: r = mk(KIND_VOWEL, 3'd1, 32'h6f000000);
            21'h0902: r = mk(KIND_CODA,  3'd3, 32'he1b98300);
            21'h0903: r = mk(KIND_CODA,  3'd3, 32'he1b8a500);
            21'h093d: r = mk(KIND_CODA,  3'd1, 32'h27000000);
            21'h0901: r = mk(KIND_CODA,  3'd3, 32'h6dcc9000);
            21'h0916: r = mk(KIND_CONS,  3'd2, 32'h6b680000);
            21'h0918: r = mk(KIND_CONS,  3'd2, 32'h67680000);
            21'h091b: r = mk(KIND_CONS,  3'd2, 32'h63680000);
            21'h091d: r = mk(KIND_CONS,  3'd2, 32'h6a680000);
            21'h0920: r = mk(KIND_CONS,  3'd4, 32'he1b9ad68);
            21'h0922: r = mk(KIND_CONS,  3'd4, 32'he1b88d68);
            21'h0925: r = mk(KIND_CONS,  3'd2, 32'h74680000);
            21'h0927: r = mk(KIND_CONS,  3'd2, 32'h64680000);
            21'h092b: r = mk(KIND_CONS,  3'd2, 32'h70680000);
            21'h092d: r = mk(KIND_CONS,  3'd2, 32'h62680000);
            21'h0915: r = mk(KIND_CONS,  3'd1, 32'h6b000000);
            21'h0917: r = mk(KIND_CONS,  3'd1, 32'h67000000);
            21'h0919: r = mk(KIND_CONS,  3'd3, 32'he1b98500);
            21'h0939: r = mk(KIND_CONS,  3'd1, 32'h68000000);
            21'h091a: r = mk(KIND_CONS,  3'd1, 32'h63000000);
            21'h091c: r = mk(KIND_CONS,  3'd1, 32'h6a000000);
            21'h091e: r = mk(KIND_CONS,  3'd2, 32'hc3b10000);
            21'h092f: r = mk(KIND_CONS,  3'd1, 32'h79000000);
            21'h0936: r = mk(KIND_CONS,  3'd2, 32'hc59b0000);
            21'h091f: r = mk(KIND_CONS,  3'd3, 32'he1b9ad00);
            21'h0921: r = mk(KIND_CONS,  3'd3, 32'he1b88d00);
            21'h0923: r = mk(KIND_CONS,  3'd3, 32'he1b98700);
            21'h0930: r = mk(KIND_CONS,  3'd1, 32'h72000000);
            21'h0937: r = mk(KIND_CONS,  3'd3, 32'he1b9a300);
            21'h0924: r = mk(KIND_CONS,  3'd1, 32'h74000000);
            21'h0926: r = mk(KIND_CONS,  3'd1, 32'h64000000);
            21'h0928: r = mk(KIND_CONS,  3'd1, 32'h6e000000);
            21'h0932: r = mk(KIND_CONS,  3'd1, 32'h6c000000);
            21'h0938: r = mk(KIND_CONS,  3'd1, 32'h73000000);
            21'h092a: r = mk(KIND_CONS,  3'd1, 32'h70000000);
            21'h092c: r = mk(KIND_CONS,  3'd1, 32'h62000000);
            21'h092e: r = mk(KIND_CONS,  3'd1, 32'h6d000000);
            21'h0935: r = mk(KIND_CONS,  3'd1, 32'h76000000);
            21'h0933: r = mk(KIND_CONS,  3'd3, 32'he1b8b700);
            21'h0966: r = mk(KIND_NUM,   3'd1, 32'h30000000);
            21'h0967: r = mk(KIND_NUM,   3'd1, 32'h31000000);
            21'h0968: r = mk(KIND_NUM,   3'd1, 32'h32000000);
            21'h0969: r = mk(KIND_NUM,   3'd1, 32'h33000000);
            21'h096a: r = mk(KIND_NUM,   3'd1, 32'h34000000);
            21'h096b: r = mk(KIND_NUM,   3'd1, 32'h35000000);
            21'h096c: r = mk(KIND_NUM,   3'd1, 32'h36000000);
            21'h096d: r = mk(KIND_NUM,   3'd1, 32'h37000000);
            21'h096e: r = mk(KIND_NUM,   3'd1, 32'h38000000);
            21'h096f: r = mk(KIND_NUM,   3'd1, 32'h39000000);
            21'h0948: r = mk(KIND_VSIGN, 3'd2, 32'h61690000);
            21'h094c: r = mk(KIND_VSIGN, 3'd2, 32'h61750000);
            21'h093e: r = mk(KIND_VSIGN, 3'd2, 32'hc4810000);
            21'h093f: r = mk(KIND_VSIGN, 3'd1, 32'h69000000);
            21'h0940: r = mk(KIND_VSIGN, 3'd2, 32'hc4ab0000);
            21'h0941: r = mk(KIND_VSIGN, 3'd1, 32'h75000000);
            21'h0942: r = mk(KIND_VSIGN, 3'd2, 32'hc5ab0000);
            21'h0943: r = mk(KIND_VSIGN, 3'd3, 32'he1b99b00);
            21'h0944: r = mk(KIND_VSIGN, 3'd3, 32'he1b99d00);
            21'h0962: r = mk(KIND_VSIGN, 3'd3, 32'he1b8b700);
            21'h0963: r = mk(KIND_VSIGN, 3'd3, 32'he1b8b900);
            21'h0947: r = mk(KIND_VSIGN, 3'd1, 32'h65000000);
            21'h094b: r = mk(KIND_VSIGN, 3'd1, 32'h6f000000);
            21'h094d: r = mk(KIND_VSIGN, 3'd0, 32'h00000000);
            21'h0965: r = mk(KIND_CODA,  3'd2, 32'h7c7c0000);
            21'h0964: r = mk(KIND_CODA,  3'd1, 32'h7c000000);
            21'h0951: r = mk(KIND_CODA,  3'd2, 32'h5c270000);
            21'h0952: r = mk(KIND_CODA,  3'd2, 32'h5c5f0000);
            default:  r = '{hit: 1'b0, kind: KIND_SPEC, len: 3'd0, bytes: 32'h0};
        endcase
        return r;
    endfunction

    // plain UTF-8 bit pattern, also for surrogates and out-of-range values
    function automatic utf8_t utf8_encode(logic [20:0] c);
        utf8_t u;
        if (c < 21'h80) begin
            u.len   = 3'd1;
            u.bytes = {24'h0, 1'b0, c[6:0]};
        end else if (c < 21'h800) begin
            u.len   = 3'd2;
            u.bytes = {16'h0, 2'b10, c[5:0], 3'b110, c[10:6]};
        end else if (c < 21'h10000) begin
            u.len   = 3'd3;
            u.bytes = {8'h0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
        end else begin
            u.len   = 3'd4;
            u.bytes = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12],
                       5'b11110, c[20:18]};
        end
        return u;
    endfunction

endpackage

@@ rtl/d2i_front.sv @@
// Front end: accepts code points, classifies them via the ROM and builds commands.
// Depends on d2i_pkg.
`timescale 1ns / 1ps

module d2i_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [20:0]    code_point,
    input  logic           in_valid,
    output logic           in_ready,
    output d2i_pkg::cmd_t  cmd,
    output logic           cmd_valid,
    input  logic           cmd_ready
);
    import d2i_pkg::*;

    logic  joiner_reg, joiner_next;
    logic  letter_reg, letter_next;
    rom_t  ent;
    utf8_t enc;
    logic  is_vsign;
    logic  accept;
    logic [CMD_W-1:0] data;
    logic [3:0]       n;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    assign ent      = rom_lookup(code_point);
    assign enc      = utf8_encode(code_point);
    assign is_vsign = ent.hit && (ent.kind == KIND_VSIGN);

    // pack the new bytes in order: pending joiner, non-joiner, spelling, inherent a
    always_comb
    begin
        data = '0;
        n    = 4'd0;
        if (joiner_reg)
        begin
            data = CMD_W'(ZWJ_UTF8);
            n    = 4'd3;
        end
        if (ent.hit)
        begin
            if (ent.kind == KIND_VOWEL && letter_reg)
            begin
                data = data | (CMD_W'(ZWNJ_UTF8) << {n, 3'b000});
                n    = n + 4'd3;
            end
            data = data | (CMD_W'(ent.bytes) << {n, 3'b000});
            n    = n + 4'(ent.len);
            if (ent.kind == KIND_CONS)
            begin
                data = data | (CMD_W'(INHERENT_A) << {n, 3'b000});
                n    = n + 4'd1;
            end
        end
        else if (code_point != CP_ZWJ && code_point != '0)
        begin
            data = data | (CMD_W'(enc.bytes) << {n, 3'b000});
            n    = n + 4'(enc.len);
        end
    end

    always_comb
    begin
        cmd.data      = data;
        cmd.len       = n;
        cmd.drop_last = joiner_reg && is_vsign;
        cmd.drop_if_a = is_vsign && !joiner_reg;
        cmd.flush     = (code_point == '0);
    end

    // context for the next item; a flush clears both
    always_comb
    begin
        joiner_next = joiner_reg;
        letter_next = letter_reg;
        if (accept)
        begin
            joiner_next = (code_point == CP_ZWJ);
            letter_next = ent.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joiner_reg <= 1'b0;
            letter_reg <= 1'b0;
        end
        else
        begin
            joiner_reg <= joiner_next;
            letter_reg <= letter_next;
        end
    end

endmodule

@@ rtl/d2i_cmdq.sv @@
// Two-entry command queue between front and back.
// Depends on d2i_pkg.
`timescale 1ns / 1ps

module d2i_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  d2i_pkg::cmd_t  push_cmd,
    input  logic           push_valid,
    output logic           push_ready,
    output d2i_pkg::cmd_t  pop_cmd,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import d2i_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/d2i_back.sv @@
// Back end: merges commands into the hold buffer and releases bytes one per cycle,
// unless out_ready stalls it. Depends on d2i_pkg.
`timescale 1ns / 1ps

module d2i_back #(
    parameter int HOLD_DEPTH = d2i_pkg::HOLD_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  d2i_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           text_end,
    output logic           out_valid,
    input  logic           out_ready
);
    import d2i_pkg::*;

    localparam int W  = HOLD_DEPTH + CMD_BYTES;
    localparam int CW = $clog2(W + 1);
    localparam int IW = $clog2(W);

    logic [7:0]    buf_reg [W];
    logic [7:0]    buf_next [W];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          flush_reg, flush_next;
    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic          rl_reg, rl_next;
    logic          te_reg, te_next;

    logic          emitting;
    logic          out_free;
    logic [CW-1:0] kc;
    logic [CW-1:0] off;
    logic [7:0]    tail;
    logic [CMD_W-1:0] sh;

    assign emitting  = flush_reg || (cnt_reg > CW'(HOLD_DEPTH));
    assign out_free  = !ov_reg || out_ready;
    assign cmd_ready = !emitting;
    assign tail      = buf_reg[IW'(cnt_reg - 1'b1)];

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign run_last  = rl_reg;
    assign text_end  = te_reg;

    // held count after a withdrawal
    always_comb
    begin
        kc = cnt_reg;
        if (cnt_reg != '0 && (cmd.drop_last || (cmd.drop_if_a && tail == INHERENT_A)))
        begin
            kc = cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        rl_next    = rl_reg;
        te_next    = te_reg;
        off        = '0;
        sh         = '0;
        if (emitting)
        begin
            if (out_free)
            begin
                ov_next = 1'b1;
                if (cnt_reg != '0)
                begin
                    // release oldest byte, shift the rest down
                    ob_next = buf_reg[0];
                    rl_next = !flush_reg && (cnt_reg == CW'(HOLD_DEPTH + 1));
                    te_next = 1'b0;
                    for (int i = 0; i < W - 1; i++)
                    begin
                        buf_next[i] = buf_reg[i + 1];
                    end
                    buf_next[W-1] = 8'h00;
                    cnt_next      = cnt_reg - 1'b1;
                end
                else
                begin
                    // terminating zero byte closes the text
                    ob_next    = 8'h00;
                    rl_next    = 1'b1;
                    te_next    = 1'b1;
                    flush_next = 1'b0;
                end
            end
        end
        else if (cmd_valid)
        begin
            // append the new bytes behind what is kept
            for (int i = 0; i < W; i++)
            begin
                if (CW'(i) >= kc)
                begin
                    off         = CW'(i) - kc;
                    sh          = cmd.data >> {off, 3'b000};
                    buf_next[i] = sh[7:0];
                end
            end
            cnt_next   = kc + CW'(cmd.len);
            flush_next = cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            ov_reg    <= ov_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        ob_reg  <= ob_next;
        rl_reg  <= rl_next;
        te_reg  <= te_next;
    end

endmodule

@@ rtl/devanagari_to_iast_stream_top.sv @@
// Devanagari to IAST transliterator: one code point in per item, UTF-8 bytes out.
// A code point is taken by the front end and written into the command queue; the
// back end merges it into the hold buffer and then releases the bytes beyond
// HOLD_DEPTH, up to nine for one item, one per cycle while out_ready allows,
// through the single byte-wide output register; it takes no new item while it
// releases. A flush releases every byte still held or newly added and then the
// closing zero byte.
// The newest HOLD_DEPTH bytes stay held so a later vowel sign or joiner can
// withdraw one; code point 0 releases everything and ends with a zero byte
// marked text_end.
// Depends on d2i_pkg, d2i_front, d2i_cmdq, d2i_back and the defines header.
`timescale 1ns / 1ps

module devanagari_to_iast_stream_top #(
    parameter int HOLD_DEPTH = d2i_pkg::HOLD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [20:0] code_point,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        text_end,
    output logic        out_valid,
    input  logic        out_ready
);
    import d2i_pkg::*;
    `include "devanagari_to_iast_stream_top_defines.svh"

    cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready;
    logic q_valid, q_ready;

    d2i_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_point (code_point),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (f_cmd),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready)
    );

    d2i_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (f_cmd),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_cmd    (q_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    d2i_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // checks
    `D2I_ASSERT_NOW(a_end_byte, out_valid && text_end, out_byte == 8'h00 && run_last, "text end byte malformed")
    `D2I_ASSERT_NOW(a_one_drop, q_valid, !(q_cmd.drop_last && q_cmd.drop_if_a), "two withdrawals in one item")
    `D2I_ASSERT_NOW(a_flush_len, q_valid && q_cmd.flush, q_cmd.len <= 4'd3, "flush carries more than joiner bytes")
    `D2I_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last) && $stable(text_end), "output item changed while waiting")

endmodule
